@@ sv/earliest_free_server_dispatch_core_assert.svh @@
// Assertion macros used by the checker file of the dispatch core.
`ifndef EARLIEST_FREE_SERVER_DISPATCH_CORE_ASSERT_SVH
`define EARLIEST_FREE_SERVER_DISPATCH_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EFSD_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define EFSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/efsd_pkg.sv @@
`timescale 1ns / 1ps

package efsd_pkg;

   localparam int unsigned TIME_W = 48;
   localparam int unsigned COST_W = 20;
   localparam int unsigned ITEM_W = 20;
   localparam int unsigned SIDX_W = 4;
   localparam int unsigned ACT_W = 5;
   localparam int unsigned CMD_W = 1;

   localparam int unsigned MAX_SERVERS_DEF = 16;
   localparam logic [ACT_W-1:0] ACTIVE_RESET = 5'd16;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD     = 1'b0,
      CMD_DISPATCH = 1'b1
   } cmd_code_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // cost write and free-time clear for an accepted load
      logic start;  // accepted dispatch: latch job, arm scan
      logic scan;   // one step of the free-time scan
      logic mul;    // unit cost * item count
      logic add;    // free + fixed + product, saturate
      logic emit;   // write back and load result register
   } efsd_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
   } efsd_sts_type;

endpackage

@@ sv/efsd_ctrl.sv @@
`timescale 1ns / 1ps

module efsd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [efsd_pkg::CMD_W-1:0] req_command,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output efsd_pkg::efsd_cmd_type     cmd,
   input  efsd_pkg::efsd_sts_type     sts
);
   import efsd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_MUL,
      ST_ADD,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      cmd.load  = accept && (req_command == CMD_LOAD);
      cmd.start = accept && (req_command == CMD_DISPATCH);
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // wait for a free result slot
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/efsd_datapath.sv @@
`timescale 1ns / 1ps

module efsd_datapath #(
   parameter int unsigned MAX_SERVERS = efsd_pkg::MAX_SERVERS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  efsd_pkg::efsd_cmd_type      cmd,
   output efsd_pkg::efsd_sts_type      sts,
   input  logic                        csr_wr_en,
   input  logic [efsd_pkg::ACT_W-1:0]  csr_wr_data,
   input  logic [efsd_pkg::SIDX_W-1:0] req_server_index,
   input  logic [efsd_pkg::COST_W-1:0] req_fixed_cost,
   input  logic [efsd_pkg::COST_W-1:0] req_unit_cost,
   input  logic [efsd_pkg::ITEM_W-1:0] req_item_count,
   output logic [efsd_pkg::SIDX_W-1:0] rsp_chosen_server,
   output logic [efsd_pkg::TIME_W-1:0] rsp_finish_time,
   output logic [efsd_pkg::TIME_W-1:0] rsp_latest_finish,
   output logic                        rsp_saturated
);
   import efsd_pkg::*;

   localparam int unsigned IDX_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int unsigned CNT_W  = $clog2(MAX_SERVERS + 1);
   localparam int unsigned PROD_W = COST_W + ITEM_W;
   localparam int unsigned SUM_W  = TIME_W + 1;

   // server storage
   logic [TIME_W-1:0]   free_mem [MAX_SERVERS];
   logic [2*COST_W-1:0] cost_mem [MAX_SERVERS];   // {fixed, unit}
   logic [MAX_SERVERS-1:0] vld_ff, vld_in;        // free time written since clear

   logic [ACT_W-1:0]  active_ff, active_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [ITEM_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [TIME_W-1:0] best_val_ff, best_val_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [TIME_W-1:0] finish_ff, finish_in;
   logic              sat_ff, sat_in;
   logic [TIME_W-1:0] latest_ff, latest_in;

   logic [TIME_W-1:0]   rd_free_ff;
   logic                rd_vld_ff;
   logic [2*COST_W-1:0] cost_q_ff;

   logic [SIDX_W-1:0] out_server_ff, out_server_in;
   logic [TIME_W-1:0] out_finish_ff, out_finish_in;
   logic [TIME_W-1:0] out_latest_ff, out_latest_in;
   logic              out_sat_ff, out_sat_in;

   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  ld_addr;
   logic              ld_ok;
   logic [TIME_W-1:0] cur_free;
   logic [COST_W-1:0] q_fixed, q_unit;
   logic [SUM_W-1:0]  sum;
   logic [CNT_W-1:0]  n_clamp;

   assign rd_addr  = (k_ff < n_ff) ? k_ff[IDX_W-1:0] : '0;
   assign ld_ok    = 32'(req_server_index) < 32'(MAX_SERVERS);
   assign ld_addr  = IDX_W'(req_server_index);
   assign cur_free = rd_vld_ff ? rd_free_ff : '0;
   assign q_fixed  = cost_q_ff[2*COST_W-1:COST_W];
   assign q_unit   = cost_q_ff[COST_W-1:0];
   assign sum      = SUM_W'(best_val_ff) + SUM_W'(q_fixed) + SUM_W'(prod_ff);

   assign sts.scan_done = (k_ff == n_ff);

   // zero counts as one server, large values clamp to the table size
   always_comb begin
      if (active_ff == '0) begin
         n_clamp = CNT_W'(1);
      end else if (32'(active_ff) > 32'(MAX_SERVERS)) begin
         n_clamp = CNT_W'(MAX_SERVERS);
      end else begin
         n_clamp = CNT_W'(active_ff);
      end
   end

   always_comb begin
      active_in     = active_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      count_in      = count_ff;
      best_idx_in   = best_idx_ff;
      best_val_in   = best_val_ff;
      prod_in       = prod_ff;
      finish_in     = finish_ff;
      sat_in        = sat_ff;
      latest_in     = latest_ff;
      vld_in        = vld_ff;
      out_server_in = out_server_ff;
      out_finish_in = out_finish_ff;
      out_latest_in = out_latest_ff;
      out_sat_in    = out_sat_ff;

      if (csr_wr_en) begin
         active_in = csr_wr_data;
      end
      if (cmd.load && ld_ok) begin
         vld_in[ld_addr] = 1'b0;
      end
      if (cmd.start) begin
         n_in        = n_clamp;
         k_in        = '0;
         count_in    = req_item_count;
         best_idx_in = '0;
         best_val_in = '1;
      end
      if (cmd.scan) begin
         if (k_ff != '0 && cur_free < best_val_ff) begin
            best_val_in = cur_free;
            best_idx_in = IDX_W'(k_ff - CNT_W'(1));
         end
         if (k_ff != n_ff) begin
            k_in = k_ff + CNT_W'(1);
         end
      end
      if (cmd.mul) begin
         prod_in = PROD_W'(q_unit) * PROD_W'(count_ff);
      end
      if (cmd.add) begin
         sat_in    = sum[SUM_W-1];
         finish_in = sum[SUM_W-1] ? '1 : sum[TIME_W-1:0];
      end
      if (cmd.emit) begin
         vld_in[best_idx_ff] = 1'b1;
         latest_in     = (finish_ff > latest_ff) ? finish_ff : latest_ff;
         out_server_in = SIDX_W'(best_idx_ff);
         out_finish_in = finish_ff;
         out_latest_in = latest_in;
         out_sat_in    = sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         vld_ff    <= '0;
         latest_ff <= '0;
         n_ff      <= CNT_W'(1);
         k_ff      <= '0;
      end else begin
         active_ff <= active_in;
         vld_ff    <= vld_in;
         latest_ff <= latest_in;
         n_ff      <= n_in;
         k_ff      <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      best_idx_ff   <= best_idx_in;
      best_val_ff   <= best_val_in;
      prod_ff       <= prod_in;
      finish_ff     <= finish_in;
      sat_ff        <= sat_in;
      out_server_ff <= out_server_in;
      out_finish_ff <= out_finish_in;
      out_latest_ff <= out_latest_in;
      out_sat_ff    <= out_sat_in;
   end

   // free-time memory: scan read port, write-back port
   always_ff @(posedge clock) begin
      rd_free_ff <= free_mem[rd_addr];
      rd_vld_ff  <= vld_ff[rd_addr];
      if (cmd.emit) begin
         free_mem[best_idx_ff] <= finish_ff;
      end
   end

   // cost memory: written by loads, read at the winning server
   always_ff @(posedge clock) begin
      cost_q_ff <= cost_mem[best_idx_ff];
      if (cmd.load && ld_ok) begin
         cost_mem[ld_addr] <= {req_fixed_cost, req_unit_cost};
      end
   end

   assign rsp_chosen_server = out_server_ff;
   assign rsp_finish_time   = out_finish_ff;
   assign rsp_latest_finish = out_latest_ff;
   assign rsp_saturated     = out_sat_ff;

endmodule

@@ sv/earliest_free_server_dispatch_core.sv @@
`timescale 1ns / 1ps

// Earliest-free-server dispatch core. A load transfer (command 0) writes one
// server's fixed and per-item cost and resets its free time to zero; it gives
// no result. A dispatch transfer (command 1) sends the job to the active
// server with the smallest free time (lowest index on a tie), advances that
// server's free time by fixed + unit * item_count and returns one result
// transfer with the server, the finish time and the latest finish seen since
// reset. Times clip at 2^48-1 and then flag saturated. A dispatch runs a
// sequential scan of the free-time memory, one server per cycle, over the N
// active servers (csr value, zero read as one, clamped to MAX_SERVERS), then
// fetch, multiply, add and write-back. The block takes one item at a time; a
// finished result waits in an output register, so the next item can be taken
// while it is stalled. Load a server's costs before it can win a dispatch;
// costs are not cleared by reset. Write csr_wr_data only while idle.

module earliest_free_server_dispatch_core #(
   parameter int unsigned MAX_SERVERS = efsd_pkg::MAX_SERVERS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // configuration: active server count
   input  logic                        csr_wr_en,
   input  logic [efsd_pkg::ACT_W-1:0]  csr_wr_data,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [efsd_pkg::CMD_W-1:0]  req_command,
   input  logic [efsd_pkg::SIDX_W-1:0] req_server_index,
   input  logic [efsd_pkg::COST_W-1:0] req_fixed_cost,
   input  logic [efsd_pkg::COST_W-1:0] req_unit_cost,
   input  logic [efsd_pkg::ITEM_W-1:0] req_item_count,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [efsd_pkg::SIDX_W-1:0] rsp_chosen_server,
   output logic [efsd_pkg::TIME_W-1:0] rsp_finish_time,
   output logic [efsd_pkg::TIME_W-1:0] rsp_latest_finish,
   output logic                        rsp_saturated
);
   import efsd_pkg::*;

   efsd_cmd_type cmd;
   efsd_sts_type sts;

   // sequencing: accept, scan, fetch, multiply, add, emit
   efsd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .sts         (sts)
   );

   // server tables, minimum search, cost arithmetic and result register
   efsd_datapath #(
      .MAX_SERVERS (MAX_SERVERS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_server_index  (req_server_index),
      .req_fixed_cost    (req_fixed_cost),
      .req_unit_cost     (req_unit_cost),
      .req_item_count    (req_item_count),
      .rsp_chosen_server (rsp_chosen_server),
      .rsp_finish_time   (rsp_finish_time),
      .rsp_latest_finish (rsp_latest_finish),
      .rsp_saturated     (rsp_saturated)
   );

endmodule

@@ sv/efsd_checker.sv @@
`timescale 1ns / 1ps
`include "earliest_free_server_dispatch_core_assert.svh"

module efsd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [efsd_pkg::CMD_W-1:0]  req_command,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [efsd_pkg::SIDX_W-1:0] rsp_chosen_server,
   input logic [efsd_pkg::TIME_W-1:0] rsp_finish_time,
   input logic [efsd_pkg::TIME_W-1:0] rsp_latest_finish,
   input logic                        rsp_saturated
);
   import efsd_pkg::*;

   logic req_load_xfer;
   logic req_disp_xfer;
   logic rsp_ok;

   assign req_load_xfer = req_valid && !req_stall && (req_command == CMD_LOAD);
   assign req_disp_xfer = req_valid && !req_stall && (req_command == CMD_DISPATCH);
   assign rsp_ok = (rsp_latest_finish >= rsp_finish_time) &&
                   (!rsp_saturated || (rsp_finish_time == {TIME_W{1'b1}}));

   // a stalled result holds
   `EFSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_chosen_server) && $stable(rsp_finish_time) && $stable(rsp_latest_finish) && $stable(rsp_saturated), "stalled result changed")

   // a load finishes in its own cycle
   `EFSD_ASSERT_NEXT(a_load_single, clock, reset, req_load_xfer, !req_stall, "load held the block busy")

   // a dispatch transfer leaves the block busy
   `EFSD_ASSERT_NEXT(a_disp_busy, clock, reset, req_disp_xfer, req_stall, "dispatch did not block input")

   // running maximum covers this finish; clipped times read all ones
   `EFSD_ASSERT_HOLDS(a_rsp_consistent, clock, reset, rsp_valid, rsp_ok, "inconsistent result")

endmodule

bind earliest_free_server_dispatch_core efsd_checker u_efsd_checker (.*);
